// ----- sv/cyclic_rotation_compare_macros.svh -----
// Assertion macros used by the cyclic rotation compare controller.
`ifndef CYCLIC_ROTATION_COMPARE_MACROS_SVH
`define CYCLIC_ROTATION_COMPARE_MACROS_SVH

// Clocked check, off while reset is high.
`define CRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define CRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/crc_pkg.sv -----
// Package: sizes, command and order codes, and controller/datapath structs.
package crc_pkg;

  localparam int MAX_TEXT = 4096;
  localparam int ADDR_W   = $clog2(MAX_TEXT);
  localparam int LEN_W    = $clog2(MAX_TEXT + 1);

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_APPEND  = 2'd1;
  localparam logic [1:0] CMD_COMPARE = 2'd2;

  localparam logic signed [1:0] ORDER_LESS    = -2'sd1;
  localparam logic signed [1:0] ORDER_EQUAL   = 2'sd0;
  localparam logic signed [1:0] ORDER_GREATER = 2'sd1;

  typedef struct packed {
    logic clear_len;
    logic append;
    logic load_ptrs;
    logic issue;
    logic out_load;
    logic out_bad;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_start;
    logic last;
    logic rd_valid;
    logic differs;
    logic out_full;
  } dp_status_t;

endpackage

// ----- sv/crc_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface crc_req_if;
  import crc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [7:0] character;
  logic [11:0]       first_start;
  logic [11:0]       second_start;

  modport source (output valid, command, character, first_start, second_start,
                  input ready);
  modport sink   (input valid, command, character, first_start, second_start,
                  output ready);
endinterface

interface crc_res_if;
  import crc_pkg::*;
  logic              valid;
  logic              ready;
  logic signed [1:0] order;
  logic              bad_start;

  modport source (output valid, order, bad_start, input ready);
  modport sink   (input valid, order, bad_start, output ready);
endinterface

// ----- sv/crc_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module crc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- sv/crc_ctrl.sv -----
// Controller: accepts requests and sequences the rotation walk.
`include "cyclic_rotation_compare_macros.svh"

module crc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          command,
  output logic                in_ready,
  output crc_pkg::dp_cmd_t    cmd,
  input  crc_pkg::dp_status_t status
);
  import crc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE) && !status.out_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_CLEAR:  cmd.clear_len = 1'b1;
            CMD_APPEND: cmd.append    = 1'b1;
            CMD_COMPARE: begin
              if (status.bad_start) begin
                cmd.out_load = 1'b1;
                cmd.out_bad  = 1'b1;
              end else begin
                cmd.load_ptrs = 1'b1;
                state_next    = S_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (status.rd_valid && status.differs) begin
          // first difference found: drop the reads still in flight
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.issue = 1'b1;
          if (status.last) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // last character pair is on the read ports
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `CRC_ASSERT(a_load_into_empty, cmd.out_load |-> !status.out_full, "result load while full")
  `CRC_ASSERT(a_drain_has_data, (state == S_DRAIN) |-> status.rd_valid, "drain without read data")
  `CRC_ASSERT(a_read_from_run, status.rd_valid |-> ($past(state) == S_RUN), "stray read data")

endmodule

// ----- sv/crc_datapath.sv -----
// Datapath: text store, length, rotation pointers, compare and result register.
module crc_datapath (
  input  logic                clk,
  input  logic                rst,
  crc_req_if.sink             request,
  crc_res_if.source           result,
  input  crc_pkg::dp_cmd_t    cmd,
  output crc_pkg::dp_status_t status
);
  import crc_pkg::*;

  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] ptr_a;
  logic [ADDR_W-1:0] ptr_b;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] ptr_a_next;
  logic [ADDR_W-1:0] ptr_b_next;
  logic              rd_valid;
  logic [7:0]        rdata_a;
  logic [7:0]        rdata_b;
  logic              ram_we;
  logic              less;
  logic              greater;
  logic              out_valid;
  logic signed [1:0] out_order;
  logic              out_bad;

  assign ram_we = cmd.append && (len < LEN_W'(MAX_TEXT));

  crc_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (len[ADDR_W-1:0]),
    .wdata   (request.character),
    .raddr_a (ptr_a),
    .raddr_b (ptr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // advance with wrap at the text length
  assign ptr_a_next = (LEN_W'(ptr_a) + LEN_W'(1) == len) ? '0 : ptr_a + ADDR_W'(1);
  assign ptr_b_next = (LEN_W'(ptr_b) + LEN_W'(1) == len) ? '0 : ptr_b + ADDR_W'(1);

  assign less    = $signed(rdata_a) < $signed(rdata_b);
  assign greater = $signed(rdata_a) > $signed(rdata_b);

  assign status.bad_start = (LEN_W'(request.first_start) >= len) ||
                            (LEN_W'(request.second_start) >= len);
  assign status.last      = (LEN_W'(cnt) == len - LEN_W'(1));
  assign status.rd_valid  = rd_valid;
  assign status.differs   = less || greater;
  assign status.out_full  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
      if (cmd.clear_len) begin
        len <= '0;
      end else if (ram_we) begin
        len <= len + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ptrs) begin
      ptr_a <= ADDR_W'(request.first_start);
      ptr_b <= ADDR_W'(request.second_start);
      cnt   <= '0;
    end else if (cmd.issue) begin
      ptr_a <= ptr_a_next;
      ptr_b <= ptr_b_next;
      cnt   <= cnt + ADDR_W'(1);
    end
  end

  // result register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_bad <= cmd.out_bad;
      if (cmd.out_bad) begin
        out_order <= ORDER_EQUAL;
      end else if (less) begin
        out_order <= ORDER_LESS;
      end else if (greater) begin
        out_order <= ORDER_GREATER;
      end else begin
        out_order <= ORDER_EQUAL;
      end
    end
  end

  assign result.valid     = out_valid;
  assign result.order     = out_order;
  assign result.bad_start = out_bad;

endmodule

// ----- sv/cyclic_rotation_compare.sv -----
// Top level: compares two cyclic rotations of a stored text.
// Clear and append give no result.
// A compare with a bad start gives its result in the cycle after the transfer.
// Otherwise a compare walks k character pairs (k up to the text length, at most
// 4096), one pair per cycle from the dual-read text store.
// Reset empties the text; the store itself is not cleared and needs no sweep.
module cyclic_rotation_compare (
  input  logic      clk,
  input  logic      rst,
  crc_req_if.sink   request,
  crc_res_if.source result
);
  import crc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  crc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .command  (request.command),
    .in_ready (request.ready),
    .cmd      (cmd),
    .status   (status)
  );

  crc_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .cmd     (cmd),
    .status  (status)
  );

endmodule
